/* hw/rtl/bpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int MAX_BUTTONS = 3;
   localparam int NUM_BUTTONS = 3;
   localparam int CNT_W       = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CNT_W-1:0] DEBOUNCE_RST    = CNT_W'(50);
   localparam logic [CNT_W-1:0] RELEASE_RST     = CNT_W'(100);
   localparam logic [CNT_W-1:0] LONG_PRESS_RST  = CNT_W'(1000);
   localparam logic [CNT_W-1:0] DOUBLE_LONG_RST = CNT_W'(1500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_RELEASE     = 2'd1,
      CSR_LONG_PRESS  = 2'd2,
      CSR_DOUBLE_LONG = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef enum logic [6:0] {
      PH_WAIT  = 7'b0000001,
      PH_PRE   = 7'b0000010,
      PH_LCMP  = 7'b0000100,
      PH_SHORT = 7'b0001000,
      PH_LONG  = 7'b0010000,
      PH_DBL   = 7'b0100000,
      PH_END   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] release_ticks;
      logic [CNT_W-1:0] long_press_ticks;
      logic [CNT_W-1:0] double_long_ticks;
   } cfg_type;

endpackage

/* hw/rtl/bpc_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc channel interfaces
// valid/ready channels for poll tick words and event words
// ----------------------------------------------------------------------------
interface bpc_req_if;
   logic valid;
   logic ready;
   logic pressed_0;
   logic pressed_1;
   logic pressed_2;

   modport source (output valid, output pressed_0, output pressed_1, output pressed_2,
                   input ready);
   modport sink (input valid, input pressed_0, input pressed_1, input pressed_2,
                 output ready);
endinterface

interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_0;
   logic [1:0] event_1;
   logic [1:0] event_2;

   modport source (output valid, output event_0, output event_1, output event_2,
                   input ready);
   modport sink (input valid, input event_0, input event_1, input event_2,
                 output ready);
endinterface

/* hw/rtl/button_press_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_top
// output: an accepted tick word yields its event word from the merge output register
// throughput: one tick word per cycle while the event channel takes each word, set by the single output register
// reset: synchronous; every button returns to waiting with cleared counters
// and the thresholds return to 50, 100, 1000 and 1500 ticks
// ----------------------------------------------------------------------------
module button_press_classifier_top
   import bpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   bpc_req_if.sink              req_chan,
   bpc_rsp_if.source            rsp_chan
);

   cfg_type   cfg_ff;
   logic      advance;
   logic      merge_ready;
   logic      down [MAX_BUTTONS];
   event_type ev [MAX_BUTTONS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= DEBOUNCE_RST;
         cfg_ff.release_ticks     <= RELEASE_RST;
         cfg_ff.long_press_ticks  <= LONG_PRESS_RST;
         cfg_ff.double_long_ticks <= DOUBLE_LONG_RST;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE:    cfg_ff.debounce_ticks    <= csr_wdata;
            CSR_RELEASE:     cfg_ff.release_ticks     <= csr_wdata;
            CSR_LONG_PRESS:  cfg_ff.long_press_ticks  <= csr_wdata;
            CSR_DOUBLE_LONG: cfg_ff.double_long_ticks <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign req_chan.ready = merge_ready;
   assign advance        = req_chan.valid && merge_ready;

   assign down[0] = req_chan.pressed_0;
   assign down[1] = req_chan.pressed_1;
   assign down[2] = req_chan.pressed_2;

   for (genvar b = 0; b < MAX_BUTTONS; b++) begin : g_lane
      if (b < NUM_BUTTONS) begin : g_on
         bpc_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .cfg_i     (cfg_ff),
            .advance_i (advance),
            .down_i    (down[b]),
            .event_o   (ev[b])
         );
      end else begin : g_off
         assign ev[b] = EV_NONE;
      end
   end

   bpc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance_i (advance),
      .ev_i      (ev),
      .ready_o   (merge_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* hw/rtl/bpc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_lane
// per-button press classifier state machine with saturating counters
// ----------------------------------------------------------------------------
module bpc_lane
   import bpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg_i,
   input  logic      advance_i,
   input  logic      down_i,
   output event_type event_o
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] press_ff, press_in;
   logic [CNT_W-1:0] release_ff, release_in;
   logic [CNT_W-1:0] press_inc;
   logic [CNT_W-1:0] release_inc;

   assign press_inc   = (press_ff == CNT_MAX) ? press_ff : press_ff + CNT_W'(1);
   assign release_inc = (release_ff == CNT_MAX) ? release_ff : release_ff + CNT_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      press_in   = press_ff;
      release_in = release_ff;
      event_o    = EV_NONE;
      case (phase_ff)
         PH_WAIT: begin
            if (down_i) begin
               press_in = press_inc;
               if (press_inc >= cfg_i.debounce_ticks) begin
                  phase_in = PH_PRE;
                  press_in = '0;
               end
            end
         end
         PH_PRE: begin
            if (down_i) begin
               press_in = press_inc;
               if (press_inc >= cfg_i.long_press_ticks) begin
                  phase_in   = PH_LCMP;
                  press_in   = '0;
                  release_in = '0;
               end
            end else begin
               release_in = release_inc;
               if (release_inc >= cfg_i.release_ticks) begin
                  phase_in   = PH_SHORT;
                  release_in = '0;
               end
            end
         end
         PH_LCMP: begin
            if (down_i) begin
               press_in = press_inc;
               if (press_inc >= cfg_i.double_long_ticks) begin
                  phase_in = PH_DBL;
                  press_in = '0;
               end
            end else begin
               release_in = release_inc;
               if (release_inc >= cfg_i.release_ticks) begin
                  phase_in   = PH_LONG;
                  release_in = '0;
               end
            end
         end
         PH_SHORT: begin
            event_o  = EV_SHORT;
            phase_in = PH_END;
         end
         PH_LONG: begin
            event_o  = EV_LONG;
            phase_in = PH_END;
         end
         PH_DBL: begin
            event_o  = EV_DOUBLE;
            phase_in = PH_END;
         end
         PH_END: begin
            if (!down_i) begin
               phase_in = PH_WAIT;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         press_ff   <= '0;
         release_ff <= '0;
      end else if (advance_i) begin
         phase_ff   <= phase_in;
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

endmodule

/* hw/rtl/bpc_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_merge
// collects the lane events into one registered event word
// ----------------------------------------------------------------------------
module bpc_merge
   import bpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance_i,
   input  event_type ev_i [MAX_BUTTONS],
   output logic      ready_o,
   bpc_rsp_if.source rsp_chan
);

   logic      valid_ff;
   event_type ev_ff [MAX_BUTTONS];

   // output stage frees up in the same cycle it is drained
   assign ready_o = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance_i) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_i) begin
         ev_ff <= ev_i;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.event_0 = 2'(ev_ff[0]);
   assign rsp_chan.event_1 = 2'(ev_ff[1]);
   assign rsp_chan.event_2 = 2'(ev_ff[2]);

endmodule
